FILE: rtl/aiahm_pkg.sv
package aiahm_pkg;

    localparam int SAMPLE_W = 13;
    localparam int OUT_W    = 24;
    localparam int RATIO_W  = 24;
    localparam int THR_W    = 13;
    localparam int STEPS_W  = 7;
    localparam int IDX_W    = 3;
    localparam int FRAC_W   = 8;

    localparam int ADC_FULL_SCALE = 8192;
    localparam int MAX_STEPS      = 64;

    // accumulator holds at most MAX_STEPS full-scale samples
    localparam int SUM_W     = $clog2(MAX_STEPS * (2 ** SAMPLE_W - 1) + 1);
    localparam int CNT_W     = STEPS_W;
    localparam int DIV_CNT_W = $clog2(SUM_W);
    localparam int PROD_W    = SAMPLE_W + RATIO_W;
    localparam int MAP_W     = PROD_W - FRAC_W + 2;
    localparam int OUT_MAX_V = 2 ** (OUT_W - 1) - 1;

    localparam logic [IDX_W-1:0] REG_OUT_LOW       = 3'd0;
    localparam logic [IDX_W-1:0] REG_INVERSE_RATIO = 3'd1;
    localparam logic [IDX_W-1:0] REG_BORDER_THR    = 3'd2;
    localparam logic [IDX_W-1:0] REG_QUANTISE      = 3'd3;
    localparam logic [IDX_W-1:0] REG_AVERAGE_MODE  = 3'd4;
    localparam logic [IDX_W-1:0] REG_SMOOTH_STEPS  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_THR,
        ST_MUL,
        ST_MAP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic acc;
        logic div_step;
        logic thr;
        logic mul;
        logic map;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic avg_mode;
        logic acc_done;
        logic div_last;
        logic thr_pass;
        logic out_free;
    } dp_stat_t;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [MAP_W-1:0] v);
        logic signed [MAP_W-1:0] hi;
        logic signed [MAP_W-1:0] lo;
        hi = MAP_W'(OUT_MAX_V);
        lo = ~hi;
        if (v > hi) begin
            return {1'b0, {(OUT_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            return v[OUT_W-1:0];
        end
    endfunction

    // whole units, rounded toward zero
    function automatic logic signed [OUT_W-1:0] trunc_whole(input logic signed [OUT_W-1:0] v);
        logic [OUT_W-FRAC_W-1:0] hi_part;
        hi_part = v[OUT_W-1:FRAC_W];
        if (v[OUT_W-1] && (v[FRAC_W-1:0] != '0)) begin
            hi_part = hi_part + 1'b1;
        end
        return {hi_part, {FRAC_W{1'b0}}};
    endfunction

endpackage

FILE: rtl/aiahm_ctrl.sv
module aiahm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  aiahm_pkg::dp_stat_t  stat,
    output aiahm_pkg::ctrl_cmd_t cmd
);
    import aiahm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = stat.avg_mode ? ST_ACC : ST_MUL;
                end
            end
            ST_ACC:  state_next = stat.acc_done ? ST_DIV : ST_IDLE;
            ST_DIV:  state_next = stat.div_last ? ST_THR : ST_DIV;
            ST_THR:  state_next = stat.thr_pass ? ST_MUL : ST_IDLE;
            ST_MUL:  state_next = ST_MAP;
            ST_MAP:  state_next = ST_EMIT;
            ST_EMIT: state_next = stat.out_free ? ST_IDLE : ST_EMIT;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_ACC:  cmd.acc      = 1'b1;
            ST_DIV:  cmd.div_step = 1'b1;
            ST_THR:  cmd.thr      = 1'b1;
            ST_MUL:  cmd.mul      = 1'b1;
            ST_MAP:  cmd.map      = 1'b1;
            ST_EMIT: cmd.commit   = stat.out_free;
            default: cmd          = '0;
        endcase
    end

endmodule

FILE: rtl/aiahm_dp.sv
module aiahm_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr,
    input  logic [aiahm_pkg::IDX_W-1:0]          cfg_index,
    input  logic [aiahm_pkg::OUT_W-1:0]          cfg_data,
    input  logic [aiahm_pkg::SAMPLE_W-1:0]       s_sample,
    input  aiahm_pkg::ctrl_cmd_t                 cmd,
    output aiahm_pkg::dp_stat_t                  stat,
    input  logic                                 m_ready,
    output logic                                 m_valid,
    output logic                                 m_changed,
    output logic signed [aiahm_pkg::OUT_W-1:0]   m_mapped_value
);
    import aiahm_pkg::*;

    function automatic logic [SAMPLE_W-1:0] absdiff(input logic [SAMPLE_W-1:0] a,
                                                    input logic [SAMPLE_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // configuration
    logic signed [OUT_W-1:0]   out_low_reg;
    logic [RATIO_W-1:0]        inv_ratio_reg;
    logic [THR_W-1:0]          thr_reg;
    logic                      quant_reg;
    logic                      avg_mode_reg;
    logic [STEPS_W-1:0]        steps_reg;

    // item state
    logic [SAMPLE_W-1:0]       sample_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic [SUM_W-1:0]          sum_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;
    logic [SUM_W-1:0]          quo_reg;
    logic [STEPS_W-1:0]        rem_reg;
    logic [DIV_CNT_W-1:0]      div_cnt_reg;
    logic [SAMPLE_W-1:0]       mul_op_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic signed [OUT_W-1:0]   fine_reg;
    logic signed [OUT_W-1:0]   whole_reg;
    logic                      hyst_reg;
    logic [SAMPLE_W-1:0]       vac_reg;
    logic [SAMPLE_W-1:0]       vac_next;
    logic signed [OUT_W-1:0]   cur_reg;
    logic signed [OUT_W-1:0]   cur_next;
    logic [SAMPLE_W-1:0]       prev_reg;
    logic [SAMPLE_W-1:0]       prev_next;
    logic                      m_valid_reg;
    logic                      m_changed_reg;
    logic signed [OUT_W-1:0]   m_mapped_reg;

    logic [STEPS_W-1:0]        steps_eff;
    logic [SAMPLE_W-1:0]       samp_clamp;
    logic [SUM_W-1:0]          sum_add;
    logic                      acc_done;
    logic [STEPS_W:0]          trial;
    logic                      trial_ge;
    logic [SAMPLE_W-1:0]       avg_z;
    logic [SAMPLE_W-1:0]       mul_src;
    logic signed [MAP_W-1:0]   fine_sum;
    logic signed [MAP_W-1:0]   whole_sum;
    logic signed [OUT_W-1:0]   whole_t;
    logic                      upd;

    always_comb begin
        if (steps_reg == '0) begin
            steps_eff = STEPS_W'(1);
        end else if (32'(steps_reg) > MAX_STEPS) begin
            steps_eff = STEPS_W'(MAX_STEPS);
        end else begin
            steps_eff = steps_reg;
        end
    end

    always_comb begin
        if (32'(sample_reg) > ADC_FULL_SCALE - 1) begin
            samp_clamp = SAMPLE_W'(ADC_FULL_SCALE - 1);
        end else begin
            samp_clamp = sample_reg;
        end
    end

    assign sum_add  = sum_reg + SUM_W'(sample_reg);
    assign acc_done = ({1'b0, cnt_reg} + 1'b1) >= {1'b0, steps_eff};

    // restoring divide, one quotient bit per cycle, MSB first
    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_ge = trial >= {1'b0, steps_eff};

    // quotient never exceeds the sample range
    assign avg_z   = (quo_reg[SAMPLE_W-1:0] < thr_reg) ? '0 : quo_reg[SAMPLE_W-1:0];
    assign mul_src = avg_mode_reg ? mul_op_reg : samp_clamp;

    assign fine_sum  = $signed({2'b00, prod_reg[PROD_W-1:FRAC_W]}) + MAP_W'(out_low_reg);
    assign whole_sum = $signed({2'b00, prod_reg[PROD_W-1:2*FRAC_W], {FRAC_W{1'b0}}})
                       + MAP_W'(out_low_reg);
    assign whole_t   = trunc_whole(whole_reg);

    always_comb begin
        stat.avg_mode = avg_mode_reg;
        stat.acc_done = acc_done;
        stat.div_last = (div_cnt_reg == DIV_CNT_W'(SUM_W - 1));
        stat.thr_pass = absdiff(avg_z, vac_reg) > thr_reg;
        stat.out_free = !m_valid_reg || m_ready;
    end

    // accumulate, commit and config updates of the model state
    always_comb begin
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        vac_next  = vac_reg;
        cur_next  = cur_reg;
        prev_next = prev_reg;
        upd       = 1'b0;

        if (cmd.acc) begin
            if (acc_done) begin
                sum_next = '0;
                cnt_next = '0;
            end else begin
                sum_next = sum_add;
                cnt_next = cnt_reg + 1'b1;
            end
        end

        if (cmd.commit) begin
            if (avg_mode_reg) begin
                upd      = 1'b1;
                vac_next = mul_op_reg;
                cur_next = fine_reg;
            end else begin
                prev_next = samp_clamp;
                if (quant_reg) begin
                    upd = (whole_t != cur_reg) && hyst_reg;
                    if (upd) begin
                        vac_next = samp_clamp;
                        cur_next = whole_t;
                    end
                end else begin
                    upd = (samp_clamp != prev_reg);
                    if (upd) begin
                        cur_next = fine_reg;
                    end
                end
            end
        end

        if (cfg_wr) begin
            if (cfg_index == REG_OUT_LOW) begin
                cur_next = cfg_data;
            end
            if ((cfg_index == REG_AVERAGE_MODE) || (cfg_index == REG_SMOOTH_STEPS)) begin
                sum_next = '0;
                cnt_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_low_reg   <= '0;
            inv_ratio_reg <= RATIO_W'(65536);
            thr_reg       <= THR_W'(12);
            quant_reg     <= 1'b0;
            avg_mode_reg  <= 1'b0;
            steps_reg     <= STEPS_W'(1);
        end else if (cfg_wr) begin
            unique case (cfg_index)
                REG_OUT_LOW:       out_low_reg   <= cfg_data;
                REG_INVERSE_RATIO: inv_ratio_reg <= cfg_data;
                REG_BORDER_THR:    thr_reg       <= cfg_data[THR_W-1:0];
                REG_QUANTISE:      quant_reg     <= cfg_data[0];
                REG_AVERAGE_MODE:  avg_mode_reg  <= cfg_data[0];
                REG_SMOOTH_STEPS:  steps_reg     <= cfg_data[STEPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            cnt_reg     <= '0;
            vac_reg     <= '0;
            cur_reg     <= '0;
            prev_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            vac_reg  <= vac_next;
            cur_reg  <= cur_next;
            prev_reg <= prev_next;
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg <= s_sample;
        end
        if (cmd.acc) begin
            quo_reg     <= sum_add;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            quo_reg     <= {quo_reg[SUM_W-2:0], trial_ge};
            rem_reg     <= trial_ge ? STEPS_W'(trial - {1'b0, steps_eff})
                                    : trial[STEPS_W-1:0];
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (cmd.thr) begin
            mul_op_reg <= avg_z;
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(mul_src) * PROD_W'(inv_ratio_reg);
        end
        if (cmd.map) begin
            fine_reg  <= sat_out(fine_sum);
            whole_reg <= sat_out(whole_sum);
            hyst_reg  <= absdiff(samp_clamp, vac_reg) > thr_reg;
        end
        if (cmd.commit) begin
            m_changed_reg <= upd;
            m_mapped_reg  <= cur_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_changed      = m_changed_reg;
    assign m_mapped_value = m_mapped_reg;

endmodule

FILE: rtl/adc_input_average_hysteresis_map.sv
// channel   dir   handshake            payload
// s_        in    s_valid / s_ready    s_sample[12:0]
// m_        out   m_valid / m_ready    m_changed, m_mapped_value[23:0] (signed Q16.8)
// cfg_      in    cfg_valid / cfg_ready cfg_index[2:0], cfg_data[23:0]
//
// One request at a time. Direct modes: an accepted sample passes the multiply, map
// and emit states. Averaging: a sample that does not close a block is only summed;
// the closing sample also runs the 19-step serial divider and a threshold state that
// drops it, with no result, if the mean stays inside the hysteresis band. Result
// sits in an output register; a stalled m_ready holds the block in its emit state.
// Synchronous active-low reset sets config defaults, clears FSM, model and m_valid.
module adc_input_average_hysteresis_map (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [aiahm_pkg::SAMPLE_W-1:0]       s_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_changed,
    output logic signed [aiahm_pkg::OUT_W-1:0]   m_mapped_value,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [aiahm_pkg::IDX_W-1:0]          cfg_index,
    input  logic [aiahm_pkg::OUT_W-1:0]          cfg_data
);
    import aiahm_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    aiahm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    aiahm_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_sample       (s_sample),
        .cmd            (cmd),
        .stat           (stat),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_changed      (m_changed),
        .m_mapped_value (m_mapped_value)
    );

endmodule

FILE: rtl/aiahm_chk.sv
module aiahm_chk (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic                                m_changed,
    input logic signed [aiahm_pkg::OUT_W-1:0]  m_mapped_value
);
    import aiahm_pkg::*;

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_changed) && $stable(m_mapped_value))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !$rose(m_valid))
        else $error("input taken or result made right after accept");

    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while input side was open");

endmodule

bind adc_input_average_hysteresis_map aiahm_chk u_chk (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_changed      (m_changed),
    .m_mapped_value (m_mapped_value)
);
